### rtl/fspa_pkg.sv
// fspa_pkg: shared types and codes for the slot pool allocator
// used by fspa_ctrl, fspa_dp and fifo_slot_pool_allocator; no dependencies
package fspa_pkg;

  localparam int DEF_POOL_SIZE = 256;
  localparam int SLOT_W        = 8;
  localparam int SLOT_SPACE    = 1 << SLOT_W;
  localparam int CNT_W         = SLOT_W + 1;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_TRY     = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic [1:0]        action;
    logic [SLOT_W-1:0] slot;
  } in_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    logic [1:0]        status;
  } out_rsp_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/fspa_ctrl.sv
// fspa_ctrl: request sequencer of the slot pool allocator
// depends on fspa_pkg; drives fspa_dp through dp_cmd_t
module fspa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fspa_pkg::dp_stat_t stat,
  output fspa_pkg::dp_cmd_t  cmd
);
  import fspa_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/fspa_dp.sv
// fspa_dp: free queue ring, ownership map, fresh counter and result register
// depends on fspa_pkg; sequenced by fspa_ctrl
module fspa_dp #(
  parameter int POOL_SIZE = fspa_pkg::DEF_POOL_SIZE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fspa_pkg::in_req_t  in_req,
  input  fspa_pkg::dp_cmd_t  cmd,
  output fspa_pkg::dp_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output fspa_pkg::out_rsp_t out_rsp
);
  import fspa_pkg::*;

  localparam int EFF_SIZE = (POOL_SIZE > SLOT_SPACE) ? SLOT_SPACE : POOL_SIZE;
  localparam logic [CNT_W-1:0] EFF_LIM = CNT_W'(EFF_SIZE);

  logic [SLOT_W-1:0] mem [0:SLOT_SPACE-1];
  logic [SLOT_W-1:0] rd_data_r;

  in_req_t           req_r;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  fresh_r, fresh_nxt;
  logic [SLOT_SPACE-1:0] owned_r, owned_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_rsp_t          rsp_r, rsp_nxt;

  logic q_empty;
  logic fresh_ok;
  logic rel_ok;
  logic do_push;

  assign q_empty  = (count_r == '0);
  assign fresh_ok = (fresh_r < EFF_LIM);
  assign rel_ok   = ({1'b0, req_r.slot} < EFF_LIM) && owned_r[req_r.slot] && !count_r[CNT_W-1];

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_rsp       = rsp_r;

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    fresh_nxt     = fresh_r;
    owned_nxt     = owned_r;
    rsp_nxt       = rsp_r;
    do_push       = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.commit) begin
      out_valid_nxt        = 1'b1;
      rsp_nxt.granted_slot = '0;
      rsp_nxt.status       = ST_OK;
      unique case (req_r.action)
        ACT_ALLOC: begin
          if (!q_empty) begin
            rsp_nxt.granted_slot = rd_data_r;
            owned_nxt[rd_data_r] = 1'b1;
            head_nxt             = head_r + 1'b1;
            count_nxt            = count_r - 1'b1;
          end else if (fresh_ok) begin
            rsp_nxt.granted_slot           = fresh_r[SLOT_W-1:0];
            owned_nxt[fresh_r[SLOT_W-1:0]] = 1'b1;
            fresh_nxt                      = fresh_r + 1'b1;
          end else begin
            rsp_nxt.status = ST_EXHAUSTED;
          end
        end
        ACT_TRY: begin
          if (!q_empty) begin
            rsp_nxt.granted_slot = rd_data_r;
            owned_nxt[rd_data_r] = 1'b1;
            head_nxt             = head_r + 1'b1;
            count_nxt            = count_r - 1'b1;
          end else begin
            rsp_nxt.status = ST_EMPTY;
          end
        end
        ACT_RELEASE: begin
          if (rel_ok) begin
            owned_nxt[req_r.slot] = 1'b0;
            do_push               = 1'b1;
            tail_nxt              = tail_r + 1'b1;
            count_nxt             = count_r + 1'b1;
          end else begin
            rsp_nxt.status = ST_INVALID;
          end
        end
        default: begin
          rsp_nxt.status = ST_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      fresh_r     <= '0;
      owned_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      owned_r     <= owned_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rsp_r <= rsp_nxt;
    if (cmd.load) begin
      req_r <= in_req;
    end
  end

  // free queue ring
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail_r] <= req_r.slot;
    end
    if (cmd.load) begin
      rd_data_r <= mem[head_r];
    end
  end

endmodule

### rtl/fifo_slot_pool_allocator.sv
// channel | ports                          | direction
// in      | in_valid, in_ready, in_req     | request: action, slot
// out     | out_valid, out_ready, out_rsp  | result: granted_slot, status
//
// each request is registered while the free queue head is read; once the out side is free,
// it is decided and the result register is loaded from the ring, map and fresh counter.
// a new request is taken right after the result is loaded, while it waits on out.
// reset (rst_n low, synchronous) empties the queue, clears the map and the counter.
// a stalled out side holds the result; one more request is taken and held,
// then in_ready stays low until the result drains.
// top level of the slot pool allocator; depends on fspa_pkg, fspa_ctrl, fspa_dp
module fifo_slot_pool_allocator #(
  parameter int POOL_SIZE = fspa_pkg::DEF_POOL_SIZE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fspa_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output fspa_pkg::out_rsp_t out_rsp
);
  import fspa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fspa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fspa_dp #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

endmodule

### verif/tb_fifo_slot_pool_allocator.sv
// tb_fifo_slot_pool_allocator: self-checking testbench for the slot pool allocator
// a directed request table, then random request mixes checked against a local model
// depends on fspa_pkg and fifo_slot_pool_allocator
`timescale 1ns / 100ps

module tb_fifo_slot_pool_allocator;
  import fspa_pkg::*;

  localparam int          POOL         = DEF_POOL_SIZE;
  localparam int          EFF_SLOTS    = (POOL > SLOT_SPACE) ? SLOT_SPACE : POOL;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;
  localparam int          LIMIT_CYCLES = 400000;
  localparam int          LONG_HOLD    = 120;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          DIR_ROWS     = 18;

  typedef enum logic [1:0] {
    MIX_ALLOC,
    MIX_RELEASE,
    MIX_EVEN
  } req_mix_t;

  typedef struct packed {
    in_req_t  req;
    logic     typed;
    out_rsp_t rsp;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_rsp;

  out_rsp_t pending_rsp = '0;
  out_rsp_t grant_q[$];
  int       fail_cnt = 0;
  int       checked_cnt = 0;
  int       sent_cnt = 0;
  int       cycle_cnt = 0;

  logic [SLOT_W-1:0]     free_slots_q[$];
  int unsigned           fresh_next = 0;
  logic [SLOT_SPACE-1:0] owned_bits = '0;

  logic        quiet = 1'b0;
  int          hold_req_cnt = 0;
  int          hold_seen = 0;
  int          stall_left = 0;
  int unsigned ready_roll;

  dir_row_t dir_tab [DIR_ROWS];

  fifo_slot_pool_allocator #(
    .POOL_SIZE(POOL)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic out_rsp_t grant_predict(in_req_t req);
    out_rsp_t          rsp;
    logic [SLOT_W-1:0] s;
    rsp.granted_slot = '0;
    rsp.status       = ST_OK;
    case (req.action)
      ACT_ALLOC: begin
        if (free_slots_q.size() > 0) begin
          s = free_slots_q.pop_front();
          owned_bits[s] = 1'b1;
          rsp.granted_slot = s;
        end else if (fresh_next < EFF_SLOTS) begin
          s = SLOT_W'(fresh_next);
          fresh_next++;
          owned_bits[s] = 1'b1;
          rsp.granted_slot = s;
        end else begin
          rsp.status = ST_EXHAUSTED;
        end
      end
      ACT_TRY: begin
        if (free_slots_q.size() == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          s = free_slots_q.pop_front();
          owned_bits[s] = 1'b1;
          rsp.granted_slot = s;
        end
      end
      ACT_RELEASE: begin
        if (int'(req.slot) < EFF_SLOTS && owned_bits[req.slot]) begin
          owned_bits[req.slot] = 1'b0;
          free_slots_q.push_back(req.slot);
        end else begin
          rsp.status = ST_INVALID;
        end
      end
      default: begin
        rsp.status = ST_INVALID;
      end
    endcase
    return rsp;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_owned_slot();
    int unsigned start;
    int unsigned idx;
    start = $urandom_range(0, SLOT_SPACE - 1);
    for (int i = 0; i < SLOT_SPACE; i++) begin
      idx = (start + i) % SLOT_SPACE;
      if (owned_bits[idx]) begin
        return SLOT_W'(idx);
      end
    end
    return SLOT_W'(start);
  endfunction

  function automatic in_req_t gen_req(req_mix_t mix);
    in_req_t     req;
    int unsigned r;
    int unsigned a_lim;
    int unsigned t_lim;
    int unsigned rel_lim;
    int unsigned rnd_lim;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_ALLOC: begin
        a_lim = 88; t_lim = 92; rel_lim = 98; rnd_lim = 99;
      end
      MIX_RELEASE: begin
        a_lim = 15; t_lim = 25; rel_lim = 85; rnd_lim = 95;
      end
      default: begin
        a_lim = 35; t_lim = 55; rel_lim = 90; rnd_lim = 95;
      end
    endcase
    req.slot = SLOT_W'($urandom_range(0, SLOT_SPACE - 1));
    if (r < a_lim) begin
      req.action = ACT_ALLOC;
    end else if (r < t_lim) begin
      req.action = ACT_TRY;
    end else if (r < rel_lim) begin
      req.action = ACT_RELEASE;
      req.slot   = pick_owned_slot();
    end else if (r < rnd_lim) begin
      req.action = ACT_RELEASE;
    end else begin
      req.action = ACT_UNUSED;
    end
    return req;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic send_req(in_req_t req, out_rsp_t rsp, int unsigned gap);
    in_valid    <= 1'b1;
    in_req      <= req;
    pending_rsp <= rsp;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (checked_cnt < sent_cnt) @(posedge clk);
  endtask

  task automatic run_phase(req_mix_t mix, int count);
    in_req_t req;
    for (int i = 0; i < count; i++) begin
      req = gen_req(mix);
      send_req(req, grant_predict(req), pick_gap());
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_seen != hold_req_cnt) begin
      hold_seen  <= hold_req_cnt;
      out_ready  <= 1'b0;
      stall_left <= LONG_HOLD;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 70) begin
        out_ready <= 1'b1;
      end else if (ready_roll < 95) begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    out_rsp_t exp_rsp;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          $error("unexpected result: granted_slot %0d status %0d",
                 out_rsp.granted_slot, out_rsp.status);
          fail_cnt++;
        end else begin
          exp_rsp = grant_q.pop_front();
          checked_cnt++;
          if (out_rsp.granted_slot !== exp_rsp.granted_slot) begin
            $error("granted_slot: expected %0d, got %0d",
                   exp_rsp.granted_slot, out_rsp.granted_slot);
            fail_cnt++;
          end
          if (out_rsp.status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, out_rsp.status);
            fail_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        grant_q.push_back(pending_rsp);
      end
    end
  end

  initial begin
    out_rsp_t pred;
    // expected result typed in where obvious, otherwise from the model
    dir_tab = '{
      '{'{ACT_TRY,     8'd0},   1'b1, '{8'd0, ST_EMPTY}},
      '{'{ACT_RELEASE, 8'd0},   1'b1, '{8'd0, ST_INVALID}},
      '{'{ACT_UNUSED,  8'd255}, 1'b1, '{8'd0, ST_INVALID}},
      '{'{ACT_ALLOC,   8'd255}, 1'b1, '{8'd0, ST_OK}},
      '{'{ACT_ALLOC,   8'd0},   1'b1, '{8'd1, ST_OK}},
      '{'{ACT_ALLOC,   8'd0},   1'b1, '{8'd2, ST_OK}},
      '{'{ACT_RELEASE, 8'd255}, 1'b1, '{8'd0, ST_INVALID}},
      '{'{ACT_RELEASE, 8'd1},   1'b1, '{8'd0, ST_OK}},
      '{'{ACT_RELEASE, 8'd1},   1'b1, '{8'd0, ST_INVALID}},
      '{'{ACT_RELEASE, 8'd0},   1'b0, '{8'd0, ST_OK}},
      '{'{ACT_TRY,     8'd255}, 1'b0, '{8'd0, ST_OK}},
      '{'{ACT_ALLOC,   8'd170}, 1'b0, '{8'd0, ST_OK}},
      '{'{ACT_TRY,     8'd85},  1'b0, '{8'd0, ST_OK}},
      '{'{ACT_RELEASE, 8'd2},   1'b0, '{8'd0, ST_OK}},
      '{'{ACT_ALLOC,   8'd0},   1'b0, '{8'd0, ST_OK}},
      '{'{ACT_UNUSED,  8'd0},   1'b1, '{8'd0, ST_INVALID}},
      '{'{ACT_RELEASE, 8'd170}, 1'b1, '{8'd0, ST_INVALID}},
      '{'{ACT_RELEASE, 8'd85},  1'b1, '{8'd0, ST_INVALID}}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      pred = grant_predict(dir_tab[i].req);
      send_req(dir_tab[i].req, dir_tab[i].typed ? dir_tab[i].rsp : pred, pick_gap());
    end

    // fill with a mostly allocating mix, then pause until drained
    run_phase(MIX_ALLOC, 300);
    wait_drained();

    // long receiver hold while requests keep coming
    hold_req_cnt++;
    run_phase(MIX_EVEN, 150);

    quiet <= 1'b1;
    run_phase(MIX_RELEASE, 200);
    quiet <= 1'b0;
    wait_drained();

    run_phase(MIX_ALLOC, 100);
    run_phase(MIX_EVEN, 150);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (grant_q.size() != 0) begin
      $error("%0d expected results never arrived", grant_q.size());
    end
    if (fail_cnt == 0 && grant_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/fspa_pkg.sv
rtl/fspa_ctrl.sv
rtl/fspa_dp.sv
rtl/fifo_slot_pool_allocator.sv
verif/tb_fifo_slot_pool_allocator.sv
